### hw/rtl/aes_pkg.sv
// Shared types, constants and byte functions for the AES block encrypt unit.
// No dependencies; every other file in hw/rtl uses this package.
package aes_pkg;

  localparam int HALF_W     = 64;
  localparam int BLOCK_W    = 128;
  localparam int WORD_W     = 32;

  // Round key store size in 32-bit words, and its layout as 128-bit rows
  localparam int RK_WORDS   = 60;
  localparam int RK_ROWS    = RK_WORDS / 4;
  localparam int IDX_W      = $clog2(RK_WORDS);
  localparam int ROW_W      = IDX_W - 2;

  // Schedule length in words for each key size
  localparam int WORDS_128  = 44;
  localparam int WORDS_192  = 52;
  localparam int WORDS_256  = 60;

  localparam int NUM_CFG    = 5;
  localparam int CFG_ADDR_W = $clog2(8 * NUM_CFG);
  localparam int CFG_DATA_W = 64;

  typedef enum logic [2:0] {
    REG_KEY_LENGTH = 3'd0,
    REG_KEY_WORD_0 = 3'd1,
    REG_KEY_WORD_1 = 3'd2,
    REG_KEY_WORD_2 = 3'd3,
    REG_KEY_WORD_3 = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KLEN_128 = 2'd0,
    KLEN_192 = 2'd1,
    KLEN_256 = 2'd2
  } klen_t;

  localparam logic [7:0] RCON_INIT = 8'h01;
  localparam logic [7:0] GF_POLY   = 8'h1b;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
  endfunction

  function automatic logic [WORD_W-1:0] sub_word(logic [WORD_W-1:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Code 3 runs as 256-bit; a key size whose schedule does not fit the store falls back.
  function automatic klen_t active_len(logic [1:0] code);
    klen_t len;
    len = (code > 2'(KLEN_256)) ? KLEN_256 : klen_t'(code);
    if (len == KLEN_256 && RK_WORDS < WORDS_256) len = KLEN_192;
    if (len == KLEN_192 && RK_WORDS < WORDS_192) len = KLEN_128;
    return len;
  endfunction

endpackage

### hw/rtl/aes_in_if.sv
// Plaintext request channel: valid/ready handshake with two 64-bit halves.
// Depends on aes_pkg for the field width.
interface aes_in_if;
  logic                       valid;
  logic                       ready;
  logic [aes_pkg::HALF_W-1:0] plaintext_high;
  logic [aes_pkg::HALF_W-1:0] plaintext_low;

  modport source (output valid, output plaintext_high, output plaintext_low, input ready);
  modport sink   (input valid, input plaintext_high, input plaintext_low, output ready);
endinterface

### hw/rtl/aes_out_if.sv
// Ciphertext result channel: valid/ready handshake with two 64-bit halves.
// Depends on aes_pkg for the field width.
interface aes_out_if;
  logic                       valid;
  logic                       ready;
  logic [aes_pkg::HALF_W-1:0] ciphertext_high;
  logic [aes_pkg::HALF_W-1:0] ciphertext_low;

  modport source (output valid, output ciphertext_high, output ciphertext_low, input ready);
  modport sink   (input valid, input ciphertext_high, input ciphertext_low, output ready);
endinterface

### hw/rtl/aes_block_encrypt_unit.sv
// AES-128/192/256 block encrypt unit: config registers, key expansion, round engine.
// Depends on aes_pkg, aes_in_if and aes_out_if.
//
// One plaintext request yields one ciphertext block. A single round unit handles one
// round per clock, fed by one 128-bit row of the round key memory per cycle (registered
// read). A block goes through the initial AddRoundKey in S_ARK, then 10, 12 or 14 rounds
// in S_ROUND for 128, 192 or 256-bit keys, back to back while the output register drains;
// a stalled output holds the result in S_DONE. The first block after reset or after any
// register write first expands the key into the memory, one 32-bit word per cycle, for
// 44, 52 or 60 words. Registers sit at byte address 8*index on a 64-bit APB port and
// must only be written while the unit is idle.
module aes_block_encrypt_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  aes_in_if.sink                            in_ch,
  aes_out_if.source                         out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [aes_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [aes_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [aes_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import aes_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_EXPAND, S_ARK, S_ROUND, S_DONE} fsm_t;

  // Configuration registers
  logic [1:0]          key_len_r;
  logic [HALF_W-1:0]   key_r [4];
  logic                cfg_we;
  logic                cfg_clr;
  cfg_reg_t            cfg_idx;

  // Round key memory, rows of four words, word 0 in the top lane
  logic [BLOCK_W-1:0]  rk_mem [RK_ROWS];
  logic [BLOCK_W-1:0]  rk_rd_r;
  logic                mem_we;
  logic [ROW_W-1:0]    wr_row;
  logic [1:0]          wr_lane;
  logic [WORD_W-1:0]   wr_word;
  logic [ROW_W-1:0]    rd_row;

  // Control and datapath state
  fsm_t                fsm_r, fsm_nxt;
  logic                sched_valid_r, sched_valid_nxt;
  klen_t               len_r, len_nxt;
  logic [IDX_W-1:0]    exp_idx_r, exp_idx_nxt;
  logic [2:0]          exp_pos_r, exp_pos_nxt;
  logic [7:0]          rcon_r, rcon_nxt;
  logic [WORD_W-1:0]   prev_r, prev_nxt;
  logic [ROW_W-1:0]    round_r, round_nxt;
  logic [BLOCK_W-1:0]  blk_r, blk_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [BLOCK_W-1:0]  out_blk_r, out_blk_nxt;

  logic                in_fire;
  logic                slot_free;
  logic                out_load;
  logic [3:0]          nk;
  logic [IDX_W-1:0]    last_idx;
  logic [ROW_W-1:0]    rounds;
  logic                final_round;
  logic [BLOCK_W-1:0]  round_out;
  logic                in_key;
  logic [WORD_W-1:0]   key_word;
  logic [IDX_W-1:0]    old_word_idx;
  logic [IDX_W-1:0]    next_old_idx;
  logic [WORD_W-1:0]   old_word;
  logic [WORD_W-1:0]   exp_t;

  // SubBytes + ShiftRows, then MixColumns unless this is the final round
  function automatic logic [BLOCK_W-1:0] enc_round(logic [BLOCK_W-1:0] s, logic fin);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [BLOCK_W-1:0] res;
    for (int k = 0; k < 16; k++) b[k] = s[BLOCK_W-1-8*k -: 8];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[4*c+r] = SBOX[b[((c + r) % 4) * 4 + r]];
    if (!fin) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c];
        a1 = t[4*c+1];
        a2 = t[4*c+2];
        a3 = t[4*c+3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int k = 0; k < 16; k++) res[BLOCK_W-1-8*k -: 8] = t[k];
    return res;
  endfunction

  // ---------------------------------------------------------------- config port
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = cfg_reg_t'(paddr[CFG_ADDR_W-1:3]);

  always_comb begin
    cfg_clr = 1'b0;
    case (cfg_idx)
      REG_KEY_LENGTH, REG_KEY_WORD_0, REG_KEY_WORD_1,
      REG_KEY_WORD_2, REG_KEY_WORD_3: cfg_clr = cfg_we;
      default: cfg_clr = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r <= 2'd0;
      for (int k = 0; k < 4; k++) key_r[k] <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_KEY_LENGTH: key_len_r <= pwdata[1:0];
        REG_KEY_WORD_0: key_r[0]  <= pwdata;
        REG_KEY_WORD_1: key_r[1]  <= pwdata;
        REG_KEY_WORD_2: key_r[2]  <= pwdata;
        REG_KEY_WORD_3: key_r[3]  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_KEY_LENGTH: prdata = {{(CFG_DATA_W-2){1'b0}}, key_len_r};
      REG_KEY_WORD_0: prdata = key_r[0];
      REG_KEY_WORD_1: prdata = key_r[1];
      REG_KEY_WORD_2: prdata = key_r[2];
      REG_KEY_WORD_3: prdata = key_r[3];
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- round key memory
  assign wr_row  = exp_idx_r[IDX_W-1:2];
  assign wr_lane = exp_idx_r[1:0];

  always_ff @(posedge clk) begin
    if (mem_we) rk_mem[wr_row][{~wr_lane, 5'd0} +: WORD_W] <= wr_word;
    rk_rd_r <= rk_mem[rd_row];
  end

  // ---------------------------------------------------------------- schedule decode
  always_comb begin
    case (len_r)
      KLEN_128: begin
        nk = 4'd4;  last_idx = IDX_W'(WORDS_128 - 1); rounds = ROW_W'(10);
      end
      KLEN_192: begin
        nk = 4'd6;  last_idx = IDX_W'(WORDS_192 - 1); rounds = ROW_W'(12);
      end
      KLEN_256: begin
        nk = 4'd8;  last_idx = IDX_W'(WORDS_256 - 1); rounds = ROW_W'(14);
      end
      default: begin
        nk = 4'd4;  last_idx = IDX_W'(WORDS_128 - 1); rounds = ROW_W'(10);
      end
    endcase
  end

  // Key expansion word: w[i] = w[i-nk] ^ f(w[i-1]); w[i-nk] comes from the memory
  // read issued the cycle before, w[i-1] from prev_r.
  assign in_key       = exp_idx_r < IDX_W'(nk);
  assign key_word     = exp_idx_r[0] ? key_r[exp_idx_r[2:1]][31:0]
                                     : key_r[exp_idx_r[2:1]][63:32];
  assign old_word_idx = exp_idx_r - IDX_W'(nk);
  assign next_old_idx = exp_idx_r + IDX_W'(1) - IDX_W'(nk);
  assign old_word     = rk_rd_r[{~old_word_idx[1:0], 5'd0} +: WORD_W];

  always_comb begin
    if (exp_pos_r == 3'd0)
      exp_t = sub_word({prev_r[23:0], prev_r[31:24]}) ^ {rcon_r, 24'd0};
    else if (nk == 4'd8 && exp_pos_r == 3'd4)
      exp_t = sub_word(prev_r);
    else
      exp_t = prev_r;
  end

  assign final_round = (round_r == rounds);
  assign round_out   = enc_round(blk_r, final_round) ^ rk_rd_r;

  assign slot_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (fsm_r == S_IDLE) ||
                       (((fsm_r == S_ROUND) && final_round) || (fsm_r == S_DONE)) && slot_free;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // ---------------------------------------------------------------- control
  always_comb begin
    fsm_nxt         = fsm_r;
    sched_valid_nxt = sched_valid_r;
    len_nxt         = len_r;
    exp_idx_nxt     = exp_idx_r;
    exp_pos_nxt     = exp_pos_r;
    rcon_nxt        = rcon_r;
    prev_nxt        = prev_r;
    round_nxt       = round_r;
    blk_nxt         = blk_r;
    out_blk_nxt     = out_blk_r;
    out_load        = 1'b0;
    mem_we          = 1'b0;
    wr_word         = key_word;
    rd_row          = '0;

    if (cfg_clr) sched_valid_nxt = 1'b0;

    case (fsm_r)
      S_IDLE: ;
      S_EXPAND: begin
        mem_we      = 1'b1;
        wr_word     = in_key ? key_word : (old_word ^ exp_t);
        prev_nxt    = wr_word;
        exp_idx_nxt = exp_idx_r + IDX_W'(1);
        exp_pos_nxt = ({1'b0, exp_pos_r} == nk - 4'd1) ? 3'd0 : exp_pos_r + 3'd1;
        if (!in_key && exp_pos_r == 3'd0) rcon_nxt = xtime(rcon_r);
        if (exp_idx_r == last_idx) begin
          sched_valid_nxt = 1'b1;
          fsm_nxt         = S_ARK;
          rd_row          = '0;
        end else if (exp_idx_r + IDX_W'(1) < IDX_W'(nk)) begin
          // next word still comes straight from the key registers
          rd_row = '0;
        end else begin
          rd_row = next_old_idx[IDX_W-1:2];
        end
      end
      S_ARK: begin
        blk_nxt   = blk_r ^ rk_rd_r;
        round_nxt = ROW_W'(1);
        fsm_nxt   = S_ROUND;
        rd_row    = ROW_W'(1);
      end
      S_ROUND: begin
        if (final_round) begin
          rd_row = '0;
          if (slot_free) begin
            out_load    = 1'b1;
            out_blk_nxt = round_out;
            fsm_nxt     = S_IDLE;
          end else begin
            blk_nxt = round_out;
            fsm_nxt = S_DONE;
          end
        end else begin
          blk_nxt   = round_out;
          round_nxt = round_r + ROW_W'(1);
          rd_row    = round_r + ROW_W'(1);
        end
      end
      S_DONE: begin
        if (slot_free) begin
          out_load    = 1'b1;
          out_blk_nxt = blk_r;
          fsm_nxt     = S_IDLE;
        end
      end
      default: fsm_nxt = S_IDLE;
    endcase

    // New request; row 0 read is already issued this cycle
    if (in_fire) begin
      blk_nxt = {in_ch.plaintext_high, in_ch.plaintext_low};
      len_nxt = active_len(key_len_r);
      if (sched_valid_r) begin
        fsm_nxt = S_ARK;
      end else begin
        fsm_nxt     = S_EXPAND;
        exp_idx_nxt = '0;
        exp_pos_nxt = 3'd0;
        rcon_nxt    = RCON_INIT;
      end
    end

    if (out_load)          out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
    else                   out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r         <= S_IDLE;
      sched_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
      len_r         <= KLEN_128;
    end else begin
      fsm_r         <= fsm_nxt;
      sched_valid_r <= sched_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      len_r         <= len_nxt;
    end
    exp_idx_r <= exp_idx_nxt;
    exp_pos_r <= exp_pos_nxt;
    rcon_r    <= rcon_nxt;
    prev_r    <= prev_nxt;
    round_r   <= round_nxt;
    blk_r     <= blk_nxt;
    out_blk_r <= out_blk_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.ciphertext_high = out_blk_r[BLOCK_W-1:HALF_W];
  assign out_ch.ciphertext_low  = out_blk_r[HALF_W-1:0];

`ifndef ASSERT_OFF
  a_sched_set: assert property (@(posedge clk) disable iff (!rst_n)
    (fsm_r == S_EXPAND && exp_idx_r == last_idx) |=> sched_valid_r)
    else $error("schedule not marked valid after expansion");

  a_expand_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !sched_valid_r) |=> (fsm_r == S_EXPAND && exp_idx_r == '0))
    else $error("request with stale schedule did not start expansion");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (fsm_r == S_EXPAND) |-> ({1'b0, exp_pos_r} < nk))
    else $error("expansion position out of range");

  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (fsm_r == S_ROUND) |-> (round_r != '0 && round_r <= rounds))
    else $error("round counter out of range");
`endif

endmodule
